### design/lsas_pkg.sv
// Shared constants, types and state codes of the level sensor averaging and scaling block.
`default_nettype none

package lsas_pkg;

    localparam int SAMPLE_W   = 10;
    localparam int WINDOW_LEN = 5;
    localparam int SUM_W      = SAMPLE_W + $clog2(WINDOW_LEN + 1);
    localparam int ROT_CNT_W  = $clog2(WINDOW_LEN + 1);

    // The window mean is the sum times a rounded-up reciprocal of the window length.
    // With this shift the result is exact for every possible window sum.
    localparam int AVG_SHIFT   = 20;
    localparam int AVG_RECIP_W = AVG_SHIFT + 1;
    localparam int AVG_PROD_W  = SUM_W + AVG_RECIP_W;
    localparam logic [AVG_RECIP_W-1:0] AVG_RECIP =
        AVG_RECIP_W'((2 ** AVG_SHIFT + WINDOW_LEN - 1) / WINDOW_LEN);

    localparam int PCT_W  = 7;
    localparam int BAND_W = 3;

    localparam int DIVD_W    = 17;
    localparam int DIVS_W    = 10;
    localparam int DIV_CNT_W = $clog2(DIVD_W + 1);

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 24;
    localparam int CFG_ADDR_W = 1;

    localparam logic [SAMPLE_W-1:0] EMPTY_RESET    = SAMPLE_W'(5);
    localparam logic [SAMPLE_W-1:0] FULL_RESET     = SAMPLE_W'(12);
    localparam logic [SAMPLE_W-1:0] FAULT_LOW_MAX  = SAMPLE_W'(20);
    localparam logic [SAMPLE_W-1:0] FAULT_HIGH_MIN = SAMPLE_W'(1003);

    localparam logic [DIVD_W-1:0] PCT_SCALE = DIVD_W'(100);

    localparam logic [PCT_W-1:0] BAND_EMPTY_MAX = PCT_W'(10);
    localparam logic [PCT_W-1:0] BAND_LOW_MAX   = PCT_W'(25);
    localparam logic [PCT_W-1:0] BAND_HALF_MAX  = PCT_W'(50);
    localparam logic [PCT_W-1:0] BAND_GOOD_MAX  = PCT_W'(75);

    localparam logic [BAND_W-1:0] BAND_EMPTY = BAND_W'(0);
    localparam logic [BAND_W-1:0] BAND_LOW   = BAND_W'(1);
    localparam logic [BAND_W-1:0] BAND_HALF  = BAND_W'(2);
    localparam logic [BAND_W-1:0] BAND_GOOD  = BAND_W'(3);
    localparam logic [BAND_W-1:0] BAND_FULL  = BAND_W'(4);

    localparam logic [CFG_ADDR_W-1:0] REG_EMPTY_POINT = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] REG_FULL_POINT  = CFG_ADDR_W'(1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROTATE,
        ST_AVERAGE,
        ST_MAP,
        ST_PCT_GO,
        ST_PCT_WAIT,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic              start;
        logic [DIVD_W-1:0] dividend;
        logic [DIVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [DIVD_W-1:0] quotient;
    } div_rsp_t;

endpackage

`default_nettype wire

### design/lsas_cell.sv
// One slot of the sample window, handing its value to the next slot when the chain shifts.
`default_nettype none

module lsas_cell (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          shift_en,
    input  wire logic [lsas_pkg::SAMPLE_W-1:0] d_in,
    output logic      [lsas_pkg::SAMPLE_W-1:0] d_out
);

    logic [lsas_pkg::SAMPLE_W-1:0] data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            data_reg <= '0;
        end else if (shift_en) begin
            data_reg <= d_in;
        end
    end

    assign d_out = data_reg;

endmodule

`default_nettype wire

### design/lsas_div.sv
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none

module lsas_div (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire lsas_pkg::div_req_t req,
    output lsas_pkg::div_rsp_t      rsp
);

    logic [lsas_pkg::DIVS_W-1:0]    rem_reg;
    logic [lsas_pkg::DIVS_W-1:0]    rem_next;
    logic [lsas_pkg::DIVD_W-1:0]    quo_reg;
    logic [lsas_pkg::DIVD_W-1:0]    quo_next;
    logic [lsas_pkg::DIVS_W-1:0]    den_reg;
    logic [lsas_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                           busy_reg;
    logic                           done_reg;
    logic [lsas_pkg::DIVS_W:0]      rem_shift;
    logic [lsas_pkg::DIVS_W:0]      rem_diff;

    always_comb begin
        rem_shift = {rem_reg, quo_reg[lsas_pkg::DIVD_W-1]};
        rem_diff  = rem_shift - {1'b0, den_reg};
        if (!rem_diff[lsas_pkg::DIVS_W]) begin
            rem_next = rem_diff[lsas_pkg::DIVS_W-1:0];
            quo_next = {quo_reg[lsas_pkg::DIVD_W-2:0], 1'b1};
        end else begin
            rem_next = rem_shift[lsas_pkg::DIVS_W-1:0];
            quo_next = {quo_reg[lsas_pkg::DIVD_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= lsas_pkg::DIV_CNT_W'(lsas_pkg::DIVD_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - lsas_pkg::DIV_CNT_W'(1);
                if (cnt_reg == lsas_pkg::DIV_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg <= '0;
            quo_reg <= req.dividend;
            den_reg <= req.divisor;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

`default_nettype wire

### design/level_sensor_average_scale.sv
// Top level: sample window chain, averaging, calibration mapping and level banding.
// Each item is rotated through the window and averaged, except the first item after reset,
// which is used as it stands; with full_point not above empty_point the mapping divide
// is skipped.
// One item is in flight at a time: the next item is accepted only once the result of the
// last has been loaded into the output register, so a result stall holds the input.
// Reset is synchronous and active low; it clears the window and restores the calibration.
`default_nettype none

module level_sensor_average_scale (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // Bits from the lowest: sample[9:0], zero fill.
    input  wire logic [lsas_pkg::S_TDATA_W-1:0]    s_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // Bits from the lowest: level_percent[6:0], level_band[9:7], sensor_fault[10],
    // averaged_value[20:11], zero fill.
    output logic      [lsas_pkg::M_TDATA_W-1:0]    m_tdata,
    input  wire logic                              cfg_we,
    input  wire logic [lsas_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  wire logic [lsas_pkg::SAMPLE_W-1:0]     cfg_wdata
);

    lsas_pkg::state_t state_reg;
    lsas_pkg::state_t state_next;

    logic [lsas_pkg::SAMPLE_W-1:0]  empty_reg;
    logic [lsas_pkg::SAMPLE_W-1:0]  full_reg;
    logic                           primed_reg;
    logic                           primed_next;
    logic [lsas_pkg::ROT_CNT_W-1:0] rot_cnt_reg;
    logic [lsas_pkg::ROT_CNT_W-1:0] rot_cnt_next;
    logic [lsas_pkg::SUM_W-1:0]     acc_reg;
    logic [lsas_pkg::SUM_W-1:0]     acc_next;
    logic [lsas_pkg::SAMPLE_W-1:0]  avg_reg;
    logic [lsas_pkg::SAMPLE_W-1:0]  avg_next;
    logic                           fault_reg;
    logic                           fault_next;
    logic [lsas_pkg::DIVD_W-1:0]    num_reg;
    logic [lsas_pkg::DIVD_W-1:0]    num_next;
    logic [lsas_pkg::DIVS_W-1:0]    den_reg;
    logic [lsas_pkg::DIVS_W-1:0]    den_next;
    logic                           calib_ok_reg;
    logic                           calib_ok_next;
    logic [lsas_pkg::PCT_W-1:0]     pct_reg;
    logic [lsas_pkg::PCT_W-1:0]     pct_next;
    logic                           m_valid_reg;
    logic                           m_valid_next;
    logic [lsas_pkg::M_TDATA_W-1:0] m_data_reg;
    logic [lsas_pkg::M_TDATA_W-1:0] m_data_next;

    logic                            accept;
    logic                            out_load;
    logic                            shift_en;
    logic [lsas_pkg::SAMPLE_W-1:0]   sample;
    logic [lsas_pkg::SAMPLE_W-1:0]   clamped;
    logic [lsas_pkg::SAMPLE_W-1:0]   offset;
    logic [lsas_pkg::BAND_W-1:0]     band;
    logic [lsas_pkg::AVG_PROD_W-1:0] avg_prod;

    logic [lsas_pkg::SAMPLE_W-1:0] cell_out [lsas_pkg::WINDOW_LEN];
    logic [lsas_pkg::SAMPLE_W-1:0] chain_in;

    lsas_pkg::div_req_t div_req;
    lsas_pkg::div_rsp_t div_rsp;

    assign sample   = s_tdata[lsas_pkg::SAMPLE_W-1:0];
    assign s_tready = (state_reg == lsas_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_load = (state_reg == lsas_pkg::ST_OUT) && (!m_valid_reg || m_tready);
    assign shift_en = accept || (state_reg == lsas_pkg::ST_ROTATE);
    assign chain_in = accept ? sample : cell_out[lsas_pkg::WINDOW_LEN-1];
    assign avg_prod = lsas_pkg::AVG_PROD_W'(acc_reg) *
                      lsas_pkg::AVG_PROD_W'(lsas_pkg::AVG_RECIP);

    for (genvar i = 0; i < lsas_pkg::WINDOW_LEN; i++) begin : g_cell
        if (i == 0) begin : g_head
            lsas_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .shift_en (shift_en),
                .d_in     (chain_in),
                .d_out    (cell_out[i])
            );
        end else begin : g_body
            lsas_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .shift_en (shift_en),
                .d_in     (cell_out[i-1]),
                .d_out    (cell_out[i])
            );
        end
    end

    lsas_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            lsas_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = primed_reg ? lsas_pkg::ST_ROTATE : lsas_pkg::ST_MAP;
                end
            end
            lsas_pkg::ST_ROTATE: begin
                if (rot_cnt_reg == lsas_pkg::ROT_CNT_W'(lsas_pkg::WINDOW_LEN - 1)) begin
                    state_next = lsas_pkg::ST_AVERAGE;
                end
            end
            lsas_pkg::ST_AVERAGE: begin
                state_next = lsas_pkg::ST_MAP;
            end
            lsas_pkg::ST_MAP: begin
                state_next = (full_reg > empty_reg) ? lsas_pkg::ST_PCT_GO : lsas_pkg::ST_OUT;
            end
            lsas_pkg::ST_PCT_GO: begin
                state_next = lsas_pkg::ST_PCT_WAIT;
            end
            lsas_pkg::ST_PCT_WAIT: begin
                if (div_rsp.done) begin
                    state_next = lsas_pkg::ST_OUT;
                end
            end
            lsas_pkg::ST_OUT: begin
                if (out_load) begin
                    state_next = lsas_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = lsas_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (avg_reg < empty_reg) begin
            clamped = empty_reg;
        end else if (avg_reg > full_reg) begin
            clamped = full_reg;
        end else begin
            clamped = avg_reg;
        end
        offset = clamped - empty_reg;

        if (pct_reg <= lsas_pkg::BAND_EMPTY_MAX) begin
            band = lsas_pkg::BAND_EMPTY;
        end else if (pct_reg <= lsas_pkg::BAND_LOW_MAX) begin
            band = lsas_pkg::BAND_LOW;
        end else if (pct_reg <= lsas_pkg::BAND_HALF_MAX) begin
            band = lsas_pkg::BAND_HALF;
        end else if (pct_reg <= lsas_pkg::BAND_GOOD_MAX) begin
            band = lsas_pkg::BAND_GOOD;
        end else begin
            band = lsas_pkg::BAND_FULL;
        end
    end

    always_comb begin
        primed_next   = primed_reg;
        rot_cnt_next  = rot_cnt_reg;
        acc_next      = acc_reg;
        avg_next      = avg_reg;
        fault_next    = fault_reg;
        num_next      = num_reg;
        den_next      = den_reg;
        calib_ok_next = calib_ok_reg;
        pct_next      = pct_reg;
        m_data_next   = m_data_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        div_req       = '0;

        case (state_reg)
            lsas_pkg::ST_IDLE: begin
                if (accept) begin
                    primed_next  = 1'b1;
                    rot_cnt_next = '0;
                    acc_next     = '0;
                    avg_next     = sample;
                    fault_next   = (sample <= lsas_pkg::FAULT_LOW_MAX) ||
                                   (sample >= lsas_pkg::FAULT_HIGH_MIN);
                end
            end
            lsas_pkg::ST_ROTATE: begin
                rot_cnt_next = rot_cnt_reg + lsas_pkg::ROT_CNT_W'(1);
                acc_next     = acc_reg +
                               lsas_pkg::SUM_W'(cell_out[lsas_pkg::WINDOW_LEN-1]);
            end
            lsas_pkg::ST_AVERAGE: begin
                avg_next = avg_prod[lsas_pkg::AVG_SHIFT +: lsas_pkg::SAMPLE_W];
            end
            lsas_pkg::ST_MAP: begin
                calib_ok_next = full_reg > empty_reg;
                num_next      = lsas_pkg::DIVD_W'(offset) * lsas_pkg::PCT_SCALE;
                den_next      = full_reg - empty_reg;
                pct_next      = '0;
            end
            lsas_pkg::ST_PCT_GO: begin
                div_req.start    = 1'b1;
                div_req.dividend = num_reg;
                div_req.divisor  = den_reg;
            end
            lsas_pkg::ST_PCT_WAIT: begin
                if (div_rsp.done) begin
                    pct_next = div_rsp.quotient[lsas_pkg::PCT_W-1:0];
                end
            end
            lsas_pkg::ST_OUT: begin
                if (out_load) begin
                    m_valid_next = 1'b1;
                    m_data_next  = lsas_pkg::M_TDATA_W'({avg_reg, fault_reg, band, pct_reg});
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= lsas_pkg::ST_IDLE;
            primed_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
            empty_reg   <= lsas_pkg::EMPTY_RESET;
            full_reg    <= lsas_pkg::FULL_RESET;
            rot_cnt_reg <= '0;
        end else begin
            state_reg   <= state_next;
            primed_reg  <= primed_next;
            m_valid_reg <= m_valid_next;
            rot_cnt_reg <= rot_cnt_next;
            if (cfg_we && (cfg_addr == lsas_pkg::REG_EMPTY_POINT)) begin
                empty_reg <= cfg_wdata;
            end
            if (cfg_we && (cfg_addr == lsas_pkg::REG_FULL_POINT)) begin
                full_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg      <= acc_next;
        avg_reg      <= avg_next;
        fault_reg    <= fault_next;
        num_reg      <= num_next;
        den_reg      <= den_next;
        calib_ok_reg <= calib_ok_next;
        pct_reg      <= pct_next;
        m_data_reg   <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

`ifndef NO_ASSERTIONS
    a_idle_div_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == lsas_pkg::ST_IDLE) |-> !div_rsp.busy)
        else $error("divider busy while block is idle");

    a_pct_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[lsas_pkg::PCT_W-1:0] <= lsas_pkg::PCT_W'(100)))
        else $error("level percent above one hundred");

    a_bad_calib_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == lsas_pkg::ST_OUT) && !calib_ok_reg) |-> (pct_reg == '0))
        else $error("nonzero percent with inverted calibration");

    a_wait_has_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == lsas_pkg::ST_PCT_WAIT) |-> (div_rsp.busy || div_rsp.done))
        else $error("waiting on a divider that is not running");
`endif

endmodule

`default_nettype wire
